// ===== sv/ptrp_pkg.sv =====
package ptrp_pkg;

    localparam int MAX_PLANES = 64;
    localparam int IDX_W      = $clog2(MAX_PLANES);
    localparam int CNT_W      = IDX_W + 1;

    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_SELECT   = 3'd1,
        KIND_DESELECT = 3'd2,
        KIND_DRAG     = 3'd3,
        KIND_PICK     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAG_RD,
        ST_DRAG_WR,
        ST_PICK_MUL,
        ST_PICK_RD,
        ST_PICK_TEST,
        ST_OUT
    } state_t;

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] max_v;
        logic signed [33:0] min_v;
        max_v = 34'sh0_7FFF_FFFF;
        min_v = -34'sh0_8000_0000;
        if (v > max_v)
            sat32 = 32'h7FFF_FFFF;
        else if (v < min_v)
            sat32 = 32'h8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== sv/plane_table_ray_pick_core.sv =====
// Plane table with ray picking.
// Input channel: in_valid/in_stall with fields kind, half_size, index, move_x/y,
// origin_x/y/z and dir_x/y/z. Output channel: out_valid/out_stall with
// result_index and result_valid; every item gives exactly one result.
// One item is in flight at a time; in_stall is high until its result is taken,
// and the next item can be accepted in the cycle after that.
// Select, deselect and unknown kinds go straight to the result; add first
// passes the write state. Drag: memory read, then write back of the new
// offsets; the write is skipped when nothing draggable is selected.
// Pick: the oz*dx and oz*dy products are formed with the read of plane 0; then
// each plane passes a read state (registered read feeds the registered product)
// and a test state; the scan stops at the first hit.
// The plane table lives in one synchronous memory with a registered read.
// Reset empties the table (count zero) and clears the selection; entries are
// not cleared since only entries below the count are read.
// A stalled result holds on the outputs until out_stall drops.
module plane_table_ray_pick_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] half_size,
    input  logic [7:0]  index,
    input  logic [31:0] move_x,
    input  logic [31:0] move_y,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [31:0] origin_z,
    input  logic [31:0] dir_x,
    input  logic [31:0] dir_y,
    input  logic [31:0] dir_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  result_index,
    output logic        result_valid
);
    import ptrp_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [8:0]       chosen_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [5:0]       res_idx_reg;
    logic             res_ok_reg;

    // Latched item
    logic [2:0]  kind_reg;
    logic [31:0] half_reg, mx_reg, my_reg, ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic signed [64:0] ozdx_reg, ozdy_reg;
    logic [63:0] bound;

    // Plane memory: {half, off_x, off_y}
    logic [95:0] mem [MAX_PLANES];
    logic [95:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic        wr_en;
    logic [95:0] wr_data;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign result_index = res_idx_reg;
    assign result_valid = res_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Pick axis units
    logic in_x, in_y;
    logic [31:0] rd_half, rd_offx, rd_offy;
    assign rd_half = rd_data_reg[95:64];
    assign rd_offx = rd_data_reg[63:32];
    assign rd_offy = rd_data_reg[31:0];

    logic [31:0] mag_h, mag_dz;
    assign mag_h  = rd_half[31] ? 32'(-rd_half) : rd_half;
    assign mag_dz = dz_reg[31] ? 32'(-dz_reg) : dz_reg;

    logic [31:0] mag_h_reg;
    logic        h_zero_reg;
    always_ff @(posedge clk)
    begin
        mag_h_reg  <= mag_h;
        h_zero_reg <= (rd_half == 32'd0);
    end
    assign bound = 64'(mag_h_reg) * 64'(mag_dz);

    ptrp_axis u_ax
    (
        .clk    (clk),
        .o      (ox_reg),
        .off    (rd_offx),
        .dz     (dz_reg),
        .ozd    (ozdx_reg),
        .bound  (bound),
        .in_box (in_x)
    );

    ptrp_axis u_ay
    (
        .clk    (clk),
        .o      (oy_reg),
        .off    (rd_offy),
        .dz     (dz_reg),
        .ozd    (ozdy_reg),
        .bound  (bound),
        .in_box (in_y)
    );

    // Drag arithmetic (floor halving, saturating)
    logic signed [33:0] sum_x, sum_y;
    assign sum_x = 34'($signed(rd_offx)) + 34'($signed(mx_reg) >>> 1);
    assign sum_y = 34'($signed(rd_offy)) - 34'($signed(my_reg) >>> 1);

    logic away;
    assign away = (!oz_reg[31] && oz_reg != 32'd0 && !dz_reg[31] && dz_reg != 32'd0) ||
                  (oz_reg[31] && dz_reg[31]);

    // Item latch and products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            half_reg  <= half_size;
            mx_reg <= move_x;
            my_reg <= move_y;
            ox_reg <= origin_x;
            oy_reg <= origin_y;
            oz_reg <= origin_z;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
        if (state_reg == ST_PICK_MUL)
        begin
            ozdx_reg <= 65'($signed(oz_reg)) * 65'($signed(dx_reg));
            ozdy_reg <= 65'($signed(oz_reg)) * 65'($signed(dy_reg));
        end
    end

    logic [CNT_W-1:0] count_next;
    logic [8:0]       chosen_next;
    logic [IDX_W-1:0] scan_next;
    logic [5:0]       res_idx_next;
    logic             res_ok_next;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        chosen_next  = chosen_reg;
        scan_next    = scan_reg;
        res_idx_next = res_idx_reg;
        res_ok_next  = res_ok_reg;
        rd_addr = scan_reg;
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = {half_reg, 64'd0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_idx_next = '0;
                    res_ok_next  = 1'b0;
                    scan_next    = '0;
                    state_next   = ST_OUT;
                    unique case (kind)
                        KIND_ADD:      state_next = ST_DRAG_WR;
                        KIND_SELECT:   chosen_next = {1'b0, index};
                        KIND_DESELECT: chosen_next = '1;
                        KIND_DRAG:     state_next = ST_DRAG_RD;
                        KIND_PICK:     state_next = ST_PICK_MUL;
                        default:       state_next = ST_OUT;
                    endcase
                end
            end
            ST_DRAG_RD:
            begin
                // chosen index presented to memory; check range
                rd_addr = chosen_reg[IDX_W-1:0];
                if (!chosen_reg[8] && 9'(chosen_reg) < 9'(count_reg))
                    state_next = ST_DRAG_WR;
                else
                    state_next = ST_OUT;
            end
            ST_DRAG_WR:
            begin
                state_next = ST_OUT;
                if (kind_reg == KIND_ADD)
                begin
                    if (count_reg < CNT_W'(MAX_PLANES))
                    begin
                        wr_en        = 1'b1;
                        res_idx_next = 6'(count_reg);
                        res_ok_next  = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = chosen_reg[IDX_W-1:0];
                    wr_data = {rd_half, sat32(sum_x), sat32(sum_y)};
                end
            end
            ST_PICK_MUL:
            begin
                rd_addr = '0;
                if (dz_reg == 32'd0 || away || count_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_PICK_RD;
            end
            ST_PICK_RD:
                state_next = ST_PICK_TEST;
            ST_PICK_TEST:
            begin
                if (!h_zero_reg && in_x && in_y)
                begin
                    res_idx_next = 6'(scan_reg);
                    res_ok_next  = 1'b1;
                    state_next   = ST_OUT;
                end
                else if (CNT_W'(scan_reg) + 1'b1 >= count_reg)
                    state_next = ST_OUT;
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    rd_addr    = scan_reg + 1'b1;
                    state_next = ST_PICK_RD;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chosen_reg  <= '1;
            scan_reg    <= '0;
            res_idx_reg <= '0;
            res_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chosen_reg  <= chosen_next;
            scan_reg    <= scan_next;
            res_idx_reg <= res_idx_next;
            res_ok_reg  <= res_ok_next;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PLANES)) else $error("plane count over table size");
    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_valid) |-> (7'(result_index) < 7'(count_reg)))
        else $error("result index beyond table");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("accept while busy");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("count changed by other than one");
endmodule

// ===== sv/ptrp_axis.sv =====
// One axis of the pick test: |(o - off)*dz - ozd| <= bound.
// The product (o - off)*dz is registered before the compare.
module ptrp_axis
(
    input  logic               clk,
    input  logic signed [31:0] o,
    input  logic signed [31:0] off,
    input  logic signed [31:0] dz,
    input  logic signed [64:0] ozd,
    input  logic        [63:0] bound,
    output logic               in_box
);
    import ptrp_pkg::*;

    logic signed [32:0] a;
    logic signed [65:0] prod_reg;
    logic signed [66:0] diff;
    logic        [66:0] mag;

    assign a = 33'(o) - 33'(off);

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(a) * 66'(dz);
    end

    assign diff   = 67'(prod_reg) - 67'(ozd);
    assign mag    = diff[66] ? 67'(-diff) : 67'(diff);
    assign in_box = (mag <= 67'(bound));
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptrp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [31:0] half_size;
    logic [7:0]  index;
    logic [31:0] move_x;
    logic [31:0] move_y;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  result_index;
    logic        result_valid;

    plane_table_ray_pick_core dut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .half_size(half_size), .index(index),
        .move_x(move_x), .move_y(move_y),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_index(result_index), .result_valid(result_valid)
    );

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] half;
        logic [7:0]  idx;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic [5:0] idx;
        logic       ok;
    } pick_res_t;

    // directed row: command, plus an optional typed-in answer
    typedef struct packed {
        cmd_t      cmd;
        logic      has_answer;
        pick_res_t answer;
    } row_t;

    // shadow copy of the plane table
    int unsigned      table_count;
    logic signed [31:0] shadow_half[MAX_PLANES];
    logic signed [31:0] shadow_offx[MAX_PLANES];
    logic signed [31:0] shadow_offy[MAX_PLANES];
    int               chosen;

    pick_res_t expected_results[$];
    int        fail_count;
    int        result_count;
    int        hit_count;
    bit        quiet;
    row_t      rows[$];

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // |(o - off)*dz - oz*d| <= |h|*|dz|, exact
    function automatic bit axis_hit(logic signed [31:0] o, logic signed [31:0] off,
                                    logic signed [31:0] d, logic signed [31:0] oz,
                                    logic signed [31:0] dz, logic [63:0] bound);
        logic signed [127:0] p;
        p = (128'(signed'(o)) - 128'(signed'(off))) * 128'(signed'(dz))
            - 128'(signed'(oz)) * 128'(signed'(d));
        if (p < 0)
            p = -p;
        return p <= 128'(bound);
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] s;
        s = 64'(a) + b;
        if (s > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (s < -64'sh8000_0000)
            return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic pick_res_t predict_plane_cmd(cmd_t c);
        pick_res_t   r;
        logic signed [63:0] hx;
        logic signed [63:0] hy;
        logic signed [31:0] oz;
        logic signed [31:0] dz;
        logic [63:0] bound;
        logic [31:0] mh;
        logic [31:0] mdz;
        bit          away;
        r = '0;
        oz = c.oz;
        dz = c.dz;
        case (kind_t'(c.kind))
            KIND_ADD:
                if (table_count < MAX_PLANES) begin
                    shadow_half[table_count] = c.half;
                    shadow_offx[table_count] = 0;
                    shadow_offy[table_count] = 0;
                    r.idx = table_count[5:0];
                    r.ok = 1'b1;
                    table_count++;
                end
            KIND_SELECT:
                chosen = c.idx;
            KIND_DESELECT:
                chosen = -1;
            KIND_DRAG:
                if (chosen >= 0 && chosen < table_count) begin
                    // arithmetic shift floors toward minus infinity
                    hx = 64'(signed'(c.mx)) >>> 1;
                    hy = 64'(signed'(c.my)) >>> 1;
                    shadow_offx[chosen] = sat_add(shadow_offx[chosen], hx);
                    shadow_offy[chosen] = sat_add(shadow_offy[chosen], -hy);
                end
            KIND_PICK: begin
                away = (oz > 0 && dz > 0) || (oz < 0 && dz < 0);
                if (dz != 0 && !away) begin
                    mdz = dz < 0 ? -dz : dz;
                    for (int i = 0; i < table_count; i++) begin
                        if (shadow_half[i] == 0)
                            continue;
                        mh = shadow_half[i] < 0 ? -shadow_half[i] : shadow_half[i];
                        bound = 64'(mh) * 64'(mdz);
                        if (axis_hit(c.ox, shadow_offx[i], c.dx, oz, dz, bound) &&
                            axis_hit(c.oy, shadow_offy[i], c.dy, oz, dz, bound)) begin
                            r.idx = i[5:0];
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // prediction on a snapshot, so typed answers can be cross-checked
    function automatic pick_res_t predict_plane_cmd_peek(cmd_t c);
        pick_res_t r;
        int unsigned        cnt_s;
        int                 ch_s;
        logic signed [31:0] h_s[MAX_PLANES];
        logic signed [31:0] x_s[MAX_PLANES];
        logic signed [31:0] y_s[MAX_PLANES];
        cnt_s = table_count;
        ch_s = chosen;
        h_s = shadow_half;
        x_s = shadow_offx;
        y_s = shadow_offy;
        r = predict_plane_cmd(c);
        table_count = cnt_s;
        chosen = ch_s;
        shadow_half = h_s;
        shadow_offx = x_s;
        shadow_offy = y_s;
        return r;
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(0, 8)) - 4) << 16;
            default: return $urandom();
        endcase
    endfunction

    // mostly well-formed ray, usually aimed at a stored plane, with some slack
    function automatic cmd_t aimed_pick();
        cmd_t c;
        int   p;
        c = '0;
        c.kind = KIND_PICK;
        c.dz = -(32'($urandom_range(1, 4)) << 16);
        c.oz = 32'($urandom_range(0, 6)) << 16;
        c.dx = 32'(signed'($urandom_range(0, 65536)) - 32768);
        c.dy = 32'(signed'($urandom_range(0, 65536)) - 32768);
        if (table_count > 0 && $urandom_range(0, 3) != 0) begin
            p = $urandom_range(0, table_count - 1);
            c.ox = shadow_offx[p] + 32'(signed'($urandom_range(0, 262144)) - 131072);
            c.oy = shadow_offy[p] + 32'(signed'($urandom_range(0, 262144)) - 131072);
        end else begin
            c.ox = rnd32();
            c.oy = rnd32();
        end
        if ($urandom_range(0, 9) == 0)
            c.dz = rnd32();
        if ($urandom_range(0, 9) == 0)
            c.oz = rnd32();
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   sel;
        c = CMD_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            c.kind = KIND_ADD;
            c.half = $urandom_range(0, 3) == 0 ? rnd32()
                     : 32'($urandom_range(0, 4 << 16));
        end else if (sel < 27) begin
            c.kind = KIND_SELECT;
            c.idx = $urandom_range(0, 4) == 0 ? 8'($urandom())
                    : 8'($urandom_range(0, table_count > 0 ? table_count : 1));
        end else if (sel < 32) begin
            c.kind = KIND_DESELECT;
        end else if (sel < 50) begin
            c.kind = KIND_DRAG;
            if ($urandom_range(0, 4) != 0) begin
                c.mx = 32'(signed'($urandom_range(0, 524288)) - 262144);
                c.my = 32'(signed'($urandom_range(0, 524288)) - 262144);
            end else begin
                c.mx = rnd32();
                c.my = rnd32();
            end
        end else if (sel < 95) begin
            c = aimed_pick();
        end else begin
            c.kind = 3'($urandom_range(5, 7));
        end
        return c;
    endfunction

    // drive one item and wait until it is taken
    task automatic send_cmd(cmd_t c);
        {kind, half_size, index, move_x, move_y, origin_x, origin_y, origin_z,
         dir_x, dir_y, dir_z} = c;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results = {expected_results, predict_plane_cmd(c)};
        @(negedge clk);
        in_valid = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic row_t mk(logic [2:0] k, logic [31:0] h, logic [7:0] ix,
                                logic [31:0] mx, logic [31:0] my,
                                logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                logic has, logic [5:0] ai, logic ao);
        row_t r;
        r.cmd = {k, h, ix, mx, my, ox, oy, oz, dx, dy, dz};
        r.has_answer = has;
        r.answer = {ai, ao};
        return r;
    endfunction

    // append one directed row
    task automatic put_row(row_t r);
        rows = {rows, r};
    endtask

    // result checker
    always @(posedge clk) begin
        pick_res_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            if (result_valid)
                hit_count++;
            if (expected_results.size() == 0) begin
                $error("unexpected result index=%0d valid=%0d", result_index, result_valid);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (result_index !== exp_r.idx) begin
                    $error("result_index expected %0d actual %0d", exp_r.idx, result_index);
                    fail_count++;
                end
                if (result_valid !== exp_r.ok) begin
                    $error("result_valid expected %0d actual %0d", exp_r.ok, result_valid);
                    fail_count++;
                end
            end
        end
    end

    // result-side stall bursts
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        row_t r;
        cmd_t c;
        fail_count = 0;
        result_count = 0;
        hit_count = 0;
        table_count = 0;
        chosen = -1;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {kind, half_size, index, move_x, move_y, origin_x, origin_y, origin_z,
         dir_x, dir_y, dir_z} = '0;

        // directed rows
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_0000, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_ADD, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        put_row(mk(KIND_ADD, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        put_row(mk(KIND_ADD, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 1));
        put_row(mk(KIND_ADD, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 3, 1));
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_0000, 1, 0, 1));
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0,
                   32'h0001_0000, 1, 0, 0));
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 32'h0002_0000, 0, 32'h0001_0000,
                   0, 0, 32'hFFFF_0000, 0, 0, 0));
        put_row(mk(KIND_SELECT, 0, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'h0004_0000, 32'h0004_0000,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_SELECT, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'hFFFF_FFFF, 32'h0000_0003,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_PICK, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   0, 0, 0));
        put_row(mk(KIND_SELECT, 0, 8'd4, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DRAG, 0, 0, 32'h0002_0000, 32'h0002_0000,
                   0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(KIND_DESELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(3'd5, 32'hFFFF_FFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i]) begin
            r = rows[i];
            if (r.has_answer && predict_plane_cmd_peek(r.cmd) !== r.answer) begin
                $error("row %0d: table answer %p differs from prediction", i, r.answer);
                fail_count++;
            end
            send_cmd(r.cmd);
        end

        // sender holds off until the block is empty
        wait_drained();

        for (int n = 0; n < 400; n++) begin
            if (n == 200)
                wait_drained();
            if (n == 340)
                quiet = 1'b1;
            c = random_cmd();
            send_cmd(c);
        end

        // fill the table to the limit, then one refused add
        while (table_count < MAX_PLANES) begin
            c = '0;
            c.kind = KIND_ADD;
            c.half = 32'($urandom_range(1, 65536));
            send_cmd(c);
        end
        c = '0;
        c.kind = KIND_ADD;
        c.half = $urandom();
        send_cmd(c);
        for (int n = 0; n < 30; n++)
            send_cmd(aimed_pick());

        wait_drained();
        repeat (200) @(negedge clk);
        $display("Ran %0d results (%0d with valid set), table filled to %0d planes,",
                 result_count, hit_count, table_count);
        $display("covering adds, selects, saturating drags and exact ray picks.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ptrp_pkg.sv
sv/ptrp_axis.sv
sv/plane_table_ray_pick_core.sv
tb/tb_top.sv
